/* design/wlec_pkg.sv */
package wlec_pkg;

  localparam int unsigned SLOT_COUNT = 24;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);

  localparam logic [31:0] ERASED_WORD    = 32'hffff_ffff;
  localparam logic [31:0] COUNTER_SPAN   = 32'h0100_0000;
  localparam logic [31:0] DEFAULT_PERIOD = 32'd3600000;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_PRESET = 2'd2;

  localparam int unsigned OUT_W = 40;

  typedef struct packed {
    logic accept;
    logic scan;
    logic fill;
    logic fill_zero;
    logic clr_init;
    logic init_max;
    logic init_zero;
    logic wrap;
    logic calc_total;
    logic period_save;
    logic ring_save;
    logic out_load;
  } wlec_cmd_t;

  typedef struct packed {
    logic initialized;
    logic idx_last;
    logic max_erased;
    logic wrap_due;
    logic save_due;
  } wlec_stat_t;

endpackage

/* design/wlec_ctrl.sv */
module wlec_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wlec_pkg::wlec_stat_t stat,
  output wlec_pkg::wlec_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE        = 12'b0000_0000_0001,
    S_PRESET_FILL = 12'b0000_0000_0010,
    S_INIT_SCAN   = 12'b0000_0000_0100,
    S_INIT_DECIDE = 12'b0000_0000_1000,
    S_ZERO_FILL   = 12'b0000_0001_0000,
    S_WRAP_CHK    = 12'b0000_0010_0000,
    S_SAVE1_SCAN  = 12'b0000_0100_0000,
    S_SAVE1_WRITE = 12'b0000_1000_0000,
    S_TOTAL       = 12'b0001_0000_0000,
    S_SAVE2_SCAN  = 12'b0010_0000_0000,
    S_SAVE2_WRITE = 12'b0100_0000_0000,
    S_DONE        = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_cmd == wlec_pkg::CMD_SAMPLE) begin
            state_next = stat.initialized ? S_WRAP_CHK : S_INIT_SCAN;
          end else if (in_cmd == wlec_pkg::CMD_PRESET) begin
            state_next = S_PRESET_FILL;
          end
        end
      end
      S_PRESET_FILL: begin
        cmd.fill = 1'b1;
        if (stat.idx_last) begin
          cmd.clr_init = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_INIT_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.idx_last) state_next = S_INIT_DECIDE;
      end
      S_INIT_DECIDE: begin
        if (stat.max_erased) begin
          state_next = S_ZERO_FILL;
        end else begin
          cmd.init_max = 1'b1;
          state_next   = S_WRAP_CHK;
        end
      end
      S_ZERO_FILL: begin
        cmd.fill      = 1'b1;
        cmd.fill_zero = 1'b1;
        if (stat.idx_last) begin
          cmd.init_zero = 1'b1;
          state_next    = S_WRAP_CHK;
        end
      end
      S_WRAP_CHK: begin
        if (stat.wrap_due) begin
          cmd.wrap   = 1'b1;
          state_next = S_SAVE1_SCAN;
        end else begin
          state_next = S_TOTAL;
        end
      end
      S_SAVE1_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.idx_last) state_next = S_SAVE1_WRITE;
      end
      S_SAVE1_WRITE: begin
        cmd.ring_save = 1'b1;
        state_next    = S_TOTAL;
      end
      S_TOTAL: begin
        cmd.calc_total  = 1'b1;
        cmd.period_save = stat.save_due;
        state_next      = stat.save_due ? S_SAVE2_SCAN : S_DONE;
      end
      S_SAVE2_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.idx_last) state_next = S_SAVE2_WRITE;
      end
      S_SAVE2_WRITE: begin
        cmd.ring_save = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/wlec_dp.sv */
module wlec_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  wlec_pkg::wlec_cmd_t           cmd,
  output wlec_pkg::wlec_stat_t          stat,
  input  logic [1:0]                    in_cmd,
  input  logic [31:0]                   in_data,
  input  logic                          cfg_valid,
  input  logic [31:0]                   cfg_data,
  output logic [wlec_pkg::OUT_W-1:0]    out_data
);

  localparam logic [wlec_pkg::SLOT_W-1:0] LAST_IDX =
    wlec_pkg::SLOT_W'(wlec_pkg::SLOT_COUNT - 1);

  logic [31:0] ring [wlec_pkg::SLOT_COUNT];
  logic [wlec_pkg::SLOT_COUNT-1:0] slot_valid;

  logic                        initialized;
  logic [31:0]                 stored_base;
  logic [23:0]                 received_base;
  logic [31:0]                 ticks;
  logic [31:0]                 period;
  logic [wlec_pkg::SLOT_W-1:0] idx;
  logic [31:0]                 word;
  logic [31:0]                 best;
  logic [wlec_pkg::SLOT_W-1:0] best_idx;
  logic [31:0]                 save_val;
  logic [31:0]                 total;
  logic [1:0]                  writes;
  logic                        wrapped;

  logic [23:0]                 cnt;
  logic [31:0]                 slot_rd;
  logic [31:0]                 wrap_base;
  logic [31:0]                 total_calc;
  logic [wlec_pkg::SLOT_W-1:0] save_idx;
  logic                        save_hit;
  logic                        wr_en;
  logic [wlec_pkg::SLOT_W-1:0] wr_addr;
  logic [31:0]                 wr_data;

  assign cnt        = word[23:0];
  assign slot_rd    = slot_valid[idx] ? ring[idx] : wlec_pkg::ERASED_WORD;
  assign wrap_base  = stored_base + wlec_pkg::COUNTER_SPAN - {8'h00, received_base}
                      + {8'h00, cnt};
  assign total_calc = {8'h00, cnt} - {8'h00, received_base} + stored_base;
  assign save_idx   = (best_idx == LAST_IDX) ? '0 : best_idx + 1'b1;
  assign save_hit   = cmd.ring_save && (best != save_val);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = cmd.fill_zero ? 32'h0 : word;
    if (cmd.fill) begin
      wr_en = 1'b1;
    end else if (save_hit) begin
      wr_en   = 1'b1;
      wr_addr = save_idx;
      wr_data = save_val;
    end
  end

  assign stat.initialized = initialized;
  assign stat.idx_last    = (idx == LAST_IDX);
  assign stat.max_erased  = (best == wlec_pkg::ERASED_WORD);
  assign stat.wrap_due    = (received_base > cnt);
  assign stat.save_due    = (ticks >= period);

  always_ff @(posedge clk) begin
    if (wr_en) ring[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      initialized   <= 1'b0;
      stored_base   <= '0;
      received_base <= '0;
      ticks         <= '0;
      period        <= wlec_pkg::DEFAULT_PERIOD;
      idx           <= '0;
    end else begin
      if (wr_en) slot_valid[wr_addr] <= 1'b1;
      if (cfg_valid) period <= cfg_data;
      if (cmd.scan || cmd.fill) begin
        idx <= stat.idx_last ? '0 : idx + 1'b1;
      end
      if (cmd.accept && in_cmd == wlec_pkg::CMD_TICK && ticks != 32'hffff_ffff) begin
        ticks <= ticks + 1'b1;
      end
      if (cmd.clr_init) initialized <= 1'b0;
      if (cmd.init_max || cmd.init_zero) begin
        initialized   <= 1'b1;
        stored_base   <= cmd.init_max ? best : 32'h0;
        received_base <= cnt;
      end
      if (cmd.wrap) begin
        stored_base   <= wrap_base;
        received_base <= cnt;
        ticks         <= '0;
      end
      if (cmd.period_save) begin
        stored_base   <= total_calc;
        received_base <= cnt;
        ticks         <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word    <= in_data;
      writes  <= '0;
      wrapped <= 1'b0;
    end
    if (cmd.scan) begin
      if (idx == '0) begin
        best     <= slot_rd;
        best_idx <= '0;
      end else if (slot_rd > best) begin
        best     <= slot_rd;
        best_idx <= idx;
      end
    end
    if (cmd.wrap) begin
      save_val <= wrap_base;
      wrapped  <= 1'b1;
    end
    if (cmd.calc_total) total <= total_calc;
    if (cmd.period_save) save_val <= total_calc;
    if (save_hit) writes <= writes + 1'b1;
    if (cmd.out_load) out_data <= {5'b0, wrapped, writes, total};
  end

endmodule

/* design/wear_leveled_energy_counter.sv */
// Tick: counted while idle. Preset: writes the value to all N ring slots (N = 24),
// one slot per cycle. Sample: each save scans the ring for its maximum first; the first
// sample after reset or preset also scans, and zeroes the ring if it is erased.
// One word at a time; input is accepted again while a result waits at the output.
// Synchronous reset: ring reads as erased via per-slot valid bits, no clear pass.
module wear_leveled_energy_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] count_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] total_count, [33:32] slot_writes,
                                      // [34] rollover_seen, [39:35] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // save_period_ticks
);

  wlec_pkg::wlec_cmd_t  cmd;
  wlec_pkg::wlec_stat_t stat;

  assign cfg_ready = 1'b1;

  wlec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wlec_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (m_axis_tdata)
  );

endmodule

/* design/wlec_checker.sv */
module wlec_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_writes_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("slot write count out of range");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == wlec_pkg::CMD_SAMPLE
    |=> !s_axis_tready)
    else $error("sample did not occupy the block");

  a_preset_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == wlec_pkg::CMD_PRESET
    |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("preset not filling ring or produced output");

endmodule

bind wear_leveled_energy_counter wlec_checker u_wlec_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
